FILE: hdl/sle_pkg.sv
// Shared types, codes and constants for the sorted list engine.
// No dependencies; every other file uses names from here by scoped reference.
package sle_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int VAL_W        = 32;

	// command codes
	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_DELETE  = 2'd1;
	localparam logic [1:0] CMD_READOUT = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_EMPTY   = 2'd2;
	localparam logic [1:0] STAT_MISSING = 2'd3;

	// per-cycle operation broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
		logic rot;
	} cell_ctrl_t;

endpackage

FILE: hdl/sle_cell.sv
// One slot of the sorted list: holds a value and moves it to or from a neighbor.
// Depends on sle_pkg (value width, control struct).
module sle_cell (
	input  logic                               clk,
	input  sle_pkg::cell_ctrl_t                ctrl,
	input  logic signed [sle_pkg::VAL_W-1:0]   value,
	input  logic                               occ,
	input  logic                               tail,
	input  logic                               prev_lt,
	input  logic signed [sle_pkg::VAL_W-1:0]   prev_val,
	input  logic signed [sle_pkg::VAL_W-1:0]   next_val,
	input  logic signed [sle_pkg::VAL_W-1:0]   head_val,
	output logic                               lt,
	output logic                               hit,
	output logic signed [sle_pkg::VAL_W-1:0]   val
);

	logic signed [sle_pkg::VAL_W-1:0] val_q;

	// compare the stored entry against the command value
	assign lt  = occ && (val_q < value);
	assign hit = occ && !lt && prev_lt && (val_q == value);
	assign val = val_q;

	// insert: open a gap at the boundary; delete: close it; readout: rotate
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!lt) begin
				val_q <= prev_lt ? value : prev_val;
			end
		end else if (ctrl.del) begin
			if (!lt) begin
				val_q <= next_val;
			end
		end else if (ctrl.rot) begin
			val_q <= tail ? head_val : next_val;
		end
	end

endmodule

FILE: hdl/sorted_list_engine.sv
// Sorted list engine top level: a row of cells plus the command sequencer.
// Depends on sle_pkg and sle_cell.
//
// Keeps up to CAPACITY signed entries in ascending order. A command is taken
// when start is high and busy is low. Insert and delete finish in the cycle
// they are taken and answer with one strobed result in the next cycle, so they
// can run back to back. A readout holds busy high while the list rotates
// through the head cell, and streams one entry per cycle from a register fed
// by the head cell; busy falls as the final transfer is presented, and the
// list ends in its original order. An empty readout answers with one result
// in the next cycle. Results are strobed for exactly one cycle and cannot be
// stalled. Command code 3 is taken and dropped.
module sorted_list_engine #(
	parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [1:0]                        cmd,
	input  logic signed [sle_pkg::VAL_W-1:0]  value,
	output logic                              busy,
	output logic                              strobe,
	output logic [1:0]                        status,
	output logic signed [sle_pkg::VAL_W-1:0]  item,
	output logic                              last
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t                            state_q;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     rd_q;
	logic                              strobe_q;
	logic [1:0]                        status_q;
	logic                              last_q;
	logic signed [sle_pkg::VAL_W-1:0]  item_q;

	logic                              acc;
	logic                              full;
	logic                              found;
	sle_pkg::cell_ctrl_t               ctrl;

	logic signed [sle_pkg::VAL_W-1:0]  cval [CAPACITY];
	logic [CAPACITY-1:0]               clt;
	logic [CAPACITY-1:0]               chit;

	assign busy = (state_q == S_READ);
	assign acc  = start && !busy;
	assign full = (count_q == CW'(CAPACITY));
	assign found = |chit;

	// broadcast the operation to the row
	always_comb begin
		ctrl.ins = acc && (cmd == sle_pkg::CMD_INSERT) && !full;
		ctrl.del = acc && (cmd == sle_pkg::CMD_DELETE) && found;
		ctrl.rot = (state_q == S_READ);
	end

	// row of cells; each talks to its neighbors and to the head
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                              prev_lt_w;
		logic signed [sle_pkg::VAL_W-1:0]  prev_val_w;
		logic signed [sle_pkg::VAL_W-1:0]  next_val_w;

		if (i == 0) begin : g_first
			assign prev_lt_w  = 1'b1;
			assign prev_val_w = cval[0];
		end else begin : g_mid
			assign prev_lt_w  = clt[i-1];
			assign prev_val_w = cval[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign next_val_w = cval[i];
		end else begin : g_inner
			assign next_val_w = cval[i+1];
		end

		sle_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.value    (value),
			.occ      (CW'(i) < count_q),
			.tail     (count_q == CW'(i + 1)),
			.prev_lt  (prev_lt_w),
			.prev_val (prev_val_w),
			.next_val (next_val_w),
			.head_val (cval[0]),
			.lt       (clt[i]),
			.hit      (chit[i]),
			.val      (cval[i])
		);
	end

	// sequencer, entry count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_q     <= '0;
			strobe_q <= 1'b0;
			status_q <= sle_pkg::STAT_OK;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (cmd)
							sle_pkg::CMD_INSERT: begin
								strobe_q <= 1'b1;
								last_q   <= 1'b1;
								status_q <= full ? sle_pkg::STAT_FULL : sle_pkg::STAT_OK;
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							sle_pkg::CMD_DELETE: begin
								strobe_q <= 1'b1;
								last_q   <= 1'b1;
								if (count_q == '0) begin
									status_q <= sle_pkg::STAT_EMPTY;
								end else if (found) begin
									status_q <= sle_pkg::STAT_OK;
									count_q  <= count_q - CW'(1);
								end else begin
									status_q <= sle_pkg::STAT_MISSING;
								end
							end
							sle_pkg::CMD_READOUT: begin
								if (count_q == '0) begin
									strobe_q <= 1'b1;
									last_q   <= 1'b1;
									status_q <= sle_pkg::STAT_EMPTY;
								end else begin
									rd_q    <= count_q;
									state_q <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					strobe_q <= 1'b1;
					status_q <= sle_pkg::STAT_OK;
					last_q   <= (rd_q == CW'(1));
					rd_q     <= rd_q - CW'(1);
					if (rd_q == CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item is the head entry during readout, zero otherwise
	always_ff @(posedge clk) begin
		item_q <= (state_q == S_READ) ? cval[0] : '0;
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign item   = item_q;
	assign last   = last_q;

endmodule

FILE: hdl/sle_checker.sv
// Port-level checks for the sorted list engine, bound to the top level.
// Depends on sle_pkg (command and status codes).
module sle_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic [1:0]                        cmd,
	input logic signed [sle_pkg::VAL_W-1:0]  value,
	input logic                              busy,
	input logic                              strobe,
	input logic [1:0]                        status,
	input logic signed [sle_pkg::VAL_W-1:0]  item,
	input logic                              last
);

	// insert and delete answer with a single final transfer next cycle
	a_single_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == sle_pkg::CMD_INSERT || cmd == sle_pkg::CMD_DELETE)
		|=> strobe && last)
		else $error("insert/delete did not answer with one final result");

	// a readout stream continues without gaps until its last entry
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("readout stream broke before its last entry");

	// mid-stream results only occur while the engine holds off commands
	a_stream_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("readout entry presented while not busy");

	// error statuses end the answer and carry no item
	a_error_final: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != sle_pkg::STAT_OK |-> last && item == '0)
		else $error("error status with nonzero item or not final");

	// unused command code is dropped without a result
	a_unused_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == sle_pkg::CMD_UNUSED |=> !strobe)
		else $error("unused command produced a result");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (.*);

FILE: test/sorted_list_engine_checker.sv
// Checker for the sorted list engine: mirrors the sorted list, predicts every result
// and compares each strobed result with the oldest prediction. Depends on sle_pkg.
`timescale 1ns / 100ps

module sorted_list_engine_checker #(
	parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [1:0]                        cmd,
	input  logic signed [sle_pkg::VAL_W-1:0]  value,
	input  logic                              strobe,
	input  logic [1:0]                        status,
	input  logic signed [sle_pkg::VAL_W-1:0]  item,
	input  logic                              last,
	output int                                fail_count,
	output int                                pending
);

	typedef struct {
		logic [1:0]                       status;
		logic signed [sle_pkg::VAL_W-1:0] item;
		logic                             last;
	} list_reply_t;

	// mirror of the list contents, ascending
	logic signed [sle_pkg::VAL_W-1:0] list_mirror[$];
	// replies owed by the block, oldest first
	list_reply_t owed_replies[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic owe_reply(input logic [1:0] st, input logic signed [sle_pkg::VAL_W-1:0] it,
			input logic lst);
		list_reply_t r;
		r.status = st;
		r.item = it;
		r.last = lst;
		owed_replies.push_back(r);
	endtask

	// Apply one accepted command to the mirror and queue the replies it causes.
	task automatic mirror_command(input logic [1:0] c, input logic signed [sle_pkg::VAL_W-1:0] v);
		int pos;
		pos = 0;
		case (c)
			sle_pkg::CMD_INSERT: begin
				if (list_mirror.size() >= CAPACITY) begin
					owe_reply(sle_pkg::STAT_FULL, '0, 1'b1);
				end else begin
					// place after every smaller entry
					while (pos < list_mirror.size() && list_mirror[pos] < v)
						pos++;
					list_mirror.insert(pos, v);
					owe_reply(sle_pkg::STAT_OK, '0, 1'b1);
				end
			end
			sle_pkg::CMD_DELETE: begin
				if (list_mirror.size() == 0) begin
					owe_reply(sle_pkg::STAT_EMPTY, '0, 1'b1);
				end else begin
					// remove the first equal entry, if any
					while (pos < list_mirror.size() && list_mirror[pos] != v)
						pos++;
					if (pos >= list_mirror.size()) begin
						owe_reply(sle_pkg::STAT_MISSING, '0, 1'b1);
					end else begin
						list_mirror.delete(pos);
						owe_reply(sle_pkg::STAT_OK, '0, 1'b1);
					end
				end
			end
			sle_pkg::CMD_READOUT: begin
				if (list_mirror.size() == 0) begin
					owe_reply(sle_pkg::STAT_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < list_mirror.size(); i++)
						owe_reply(sle_pkg::STAT_OK, list_mirror[i], i == list_mirror.size() - 1);
				end
			end
			default: begin
				// unused code: dropped without a reply
			end
		endcase
	endtask

	// Compare one result transfer with the oldest owed reply.
	task automatic match_reply();
		list_reply_t exp;
		if (owed_replies.size() == 0) begin
			$error("unexpected result: status %0d item %0d last %0d", status, item, last);
			fail_count++;
		end else begin
			exp = owed_replies.pop_front();
			if (status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, status);
				fail_count++;
			end
			if (item !== exp.item) begin
				$error("item: expected %0d, actual %0d", exp.item, item);
				fail_count++;
			end
			if (last !== exp.last) begin
				$error("last: expected %0d, actual %0d", exp.last, last);
				fail_count++;
			end
		end
	endtask

	// Check results first: they belong to commands taken at earlier edges.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe === 1'b1)
				match_reply();
			else if (strobe !== 1'b0) begin
				$error("strobe: expected 0 or 1, actual %b", strobe);
				fail_count++;
			end
			if (start && busy === 1'b0)
				mirror_command(cmd, value);
		end
		pending = owed_replies.size();
	end

endmodule

FILE: test/sorted_list_engine_test.sv
// Testbench top for the sorted list engine: clock, reset and command stimulus.
// Depends on sle_pkg, sorted_list_engine and sorted_list_engine_checker.
`timescale 1ns / 100ps

module sorted_list_engine_test;

	localparam int PHASE_ITEMS = 127;

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic [1:0]                        cmd;
	logic signed [sle_pkg::VAL_W-1:0]  value;
	logic                              busy;
	logic                              strobe;
	logic [1:0]                        status;
	logic signed [sle_pkg::VAL_W-1:0]  item;
	logic                              last;
	int                                fail_count;
	int                                pending;

	// values inserted so far, used to aim deletes at present entries
	logic signed [sle_pkg::VAL_W-1:0] inserted_pool[$];
	int random_issued;

	sorted_list_engine #(.CAPACITY(sle_pkg::CAPACITY_DEF)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .value(value),
		.busy(busy), .strobe(strobe), .status(status), .item(item), .last(last)
	);

	sorted_list_engine_checker #(.CAPACITY(sle_pkg::CAPACITY_DEF)) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .value(value),
		.strobe(strobe), .status(status), .item(item), .last(last),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Present a command at the falling edge and hold it until the transfer.
	task automatic send_command(input logic [1:0] c, input logic signed [sle_pkg::VAL_W-1:0] v);
		@(negedge clk);
		start = 1'b1;
		cmd = c;
		value = v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// With a chance of idle_pct percent, drop start with junk on the command fields.
	task automatic maybe_idle(input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			cmd = 2'($urandom);
			value = $urandom;
			repeat ($urandom_range(0, 4))
				@(negedge clk);
		end
	endtask

	// Favor extremes and a narrow band so duplicates and hits are common.
	function automatic logic signed [sle_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2, 3: return $urandom_range(16) - 8;
			default: return $urandom;
		endcase
	endfunction

	// Alternate fill and drain stretches so the list goes full and empty.
	task automatic run_random(input int count, input int idle_pct);
		int r;
		int idx;
		logic [1:0] c;
		logic signed [sle_pkg::VAL_W-1:0] v;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if ((random_issued / 80) % 2 == 0)
				c = r < 70 ? sle_pkg::CMD_INSERT : r < 82 ? sle_pkg::CMD_DELETE :
					r < 96 ? sle_pkg::CMD_READOUT : sle_pkg::CMD_UNUSED;
			else
				c = r < 15 ? sle_pkg::CMD_INSERT : r < 80 ? sle_pkg::CMD_DELETE :
					r < 96 ? sle_pkg::CMD_READOUT : sle_pkg::CMD_UNUSED;
			if (c == sle_pkg::CMD_DELETE && inserted_pool.size() != 0 &&
					$urandom_range(99) < 70) begin
				idx = $urandom_range(inserted_pool.size() - 1);
				v = inserted_pool[idx];
				inserted_pool.delete(idx);
			end else begin
				v = pick_value();
			end
			if (c == sle_pkg::CMD_INSERT) begin
				inserted_pool.push_back(v);
				if (inserted_pool.size() > 64)
					void'(inserted_pool.pop_front());
			end
			send_command(c, v);
			random_issued++;
			maybe_idle(idle_pct);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = sle_pkg::CMD_INSERT;
		value = '0;
		random_issued = 0;
		repeat (11)
			@(negedge clk);
		arst_n = 1'b1;

		// directed: empty list cases, sole entry, extremes, duplicates, misses
		send_command(sle_pkg::CMD_READOUT, 32'sd0);
		send_command(sle_pkg::CMD_DELETE, 32'sd5);
		send_command(sle_pkg::CMD_UNUSED, 32'sh1234_5678);
		send_command(sle_pkg::CMD_INSERT, 32'sd0);
		send_command(sle_pkg::CMD_DELETE, 32'sd0);
		send_command(sle_pkg::CMD_READOUT, 32'shffff_ffff);
		send_command(sle_pkg::CMD_INSERT, 32'sh7fff_ffff);
		send_command(sle_pkg::CMD_INSERT, 32'sh8000_0000);
		send_command(sle_pkg::CMD_INSERT, -32'sd1);
		send_command(sle_pkg::CMD_INSERT, 32'sh5555_5555);
		send_command(sle_pkg::CMD_INSERT, 32'shaaaa_aaaa);
		send_command(sle_pkg::CMD_INSERT, -32'sd1);
		send_command(sle_pkg::CMD_READOUT, 32'sd0);
		send_command(sle_pkg::CMD_DELETE, 32'sd12345);
		send_command(sle_pkg::CMD_DELETE, 32'sh8000_0000);
		send_command(sle_pkg::CMD_DELETE, 32'sh7fff_ffff);
		send_command(sle_pkg::CMD_DELETE, -32'sd1);
		send_command(sle_pkg::CMD_READOUT, 32'sd0);
		send_command(sle_pkg::CMD_UNUSED, 32'shffff_ffff);
		maybe_idle(100);
		send_command(sle_pkg::CMD_READOUT, 32'sd0);

		// random: sender idles rarely, then often, then never
		run_random(PHASE_ITEMS, 23);
		run_random(PHASE_ITEMS, 65);
		run_random(PHASE_ITEMS - 1, 0);

		// drain the owed results, then watch for stray strobes
		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("sorted_list_engine_test OK");
		else
			$display("sorted_list_engine_test NOT OK");
		$finish;
	end

	// abort a hung run
	initial begin
		#5_000_000;
		$display("sorted_list_engine_test NOT OK");
		$finish;
	end

endmodule
